### sv/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int CELL_W = 15;
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int COL_CW = $clog2(COLUMNS + 1);
  localparam int RD_SUM_W = ((ROW_W > 5) ? ROW_W : 5) + 1;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [3:0] RESET_FG = 4'h7;
  localparam logic [2:0] RESET_BG = 3'h0;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_CLEAR_FG = 1'b0;
  localparam logic REG_CLEAR_BG = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [2:0] bg_color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_req_t;

  typedef struct packed {
    logic [14:0] cell_entry;
    logic [4:0]  row_now;
    logic [6:0]  col_now;
  } tcw_rsp_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                                   input logic [2:0] bg);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

### sv/tcw_cell_ram.sv
module tcw_cell_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tcw_pkg::CELL_AW-1:0]  waddr,
  input  logic [tcw_pkg::CELL_W-1:0]   wdata,
  input  logic [tcw_pkg::CELL_AW-1:0]  raddr,
  output logic [tcw_pkg::CELL_W-1:0]   rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/text_console_writer.sv
// Put of a character: the cell is written in ST_PUT, then ST_FIN strobes done. Newline
// at column c: space cells are written from c to the end of the row, one cell write per
// cycle. A scroll also clears the bottom row, kept as a circular row buffer so no rows
// are copied. Read: ST_RD0, ST_RD1 and ST_RD2 through the registered memory port. One
// request at a time; busy is high from accept until the result is strobed, and results
// cannot be stalled. After reset, busy stays high while the cell memory is cleared.
module text_console_writer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_req_t req,
  output logic              done,
  output tcw_pkg::tcw_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_SCR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_RD0  = 3'd5;
  localparam logic [2:0] ST_RD1  = 3'd6;
  localparam logic [2:0] ST_RD2  = 3'd7;

  logic [2:0]                    state;
  tcw_pkg::tcw_req_t             item;
  logic [3:0]                    clear_fg;
  logic [2:0]                    clear_bg;
  logic [tcw_pkg::ROW_W-1:0]     cursor_row;
  logic [tcw_pkg::COL_CW-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]     top;
  logic [tcw_pkg::ROW_W-1:0]     prow;
  logic [tcw_pkg::CELL_AW-1:0]   row_base;
  logic [tcw_pkg::CELL_AW-1:0]   clr_addr;
  logic [tcw_pkg::ROW_W-1:0]     rd_prow;

  logic                          we;
  logic [tcw_pkg::CELL_AW-1:0]   waddr;
  logic [tcw_pkg::CELL_W-1:0]    wdata;
  logic [tcw_pkg::CELL_AW-1:0]   raddr;
  logic [tcw_pkg::CELL_W-1:0]    rdata;

  logic                          is_newline;
  logic                          last_col;
  logic [tcw_pkg::COL_CW-1:0]    col_inc;
  logic [tcw_pkg::RD_SUM_W-1:0]  rd_sum;
  logic [tcw_pkg::RD_SUM_W-1:0]  rd_wrap;
  logic                          rd_out;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  assign is_newline = (item.char_code == tcw_pkg::NEWLINE_CODE);
  assign last_col = (cursor_col == tcw_pkg::COL_CW'(tcw_pkg::COLUMNS - 1));
  assign col_inc = cursor_col + tcw_pkg::COL_CW'(1);

  assign rd_sum = tcw_pkg::RD_SUM_W'(item.read_row) + tcw_pkg::RD_SUM_W'(top);
  assign rd_wrap = (rd_sum >= tcw_pkg::RD_SUM_W'(tcw_pkg::ROWS)) ?
                   rd_sum - tcw_pkg::RD_SUM_W'(tcw_pkg::ROWS) : rd_sum;
  assign rd_out = (int'(item.read_row) >= tcw_pkg::ROWS) ||
                  (int'(item.read_col) >= tcw_pkg::COLUMNS);

  assign raddr = tcw_pkg::CELL_AW'(rd_prow) * tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS)
               + tcw_pkg::CELL_AW'(item.read_col);

  always_comb begin
    we = 1'b0;
    waddr = row_base + tcw_pkg::CELL_AW'(cursor_col);
    wdata = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, clear_fg, clear_bg);
    unique case (state)
      ST_CLR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, tcw_pkg::RESET_FG, tcw_pkg::RESET_BG);
      end
      ST_PUT: begin
        we = 1'b1;
        wdata = tcw_pkg::make_cell(is_newline ? tcw_pkg::SPACE_CODE : item.char_code,
                                   item.fg_color, item.bg_color);
      end
      ST_SCR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  tcw_cell_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_fg <= tcw_pkg::RESET_FG;
      clear_bg <= tcw_pkg::RESET_BG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcw_pkg::REG_CLEAR_FG: clear_fg <= cfg_data;
        tcw_pkg::REG_CLEAR_BG: clear_bg <= cfg_data[2:0];
        default: clear_fg <= clear_fg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      clr_addr <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      top <= '0;
      prow <= '0;
      row_base <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + tcw_pkg::CELL_AW'(1);
          if (clr_addr == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item <= req;
            state <= (req.cmd == tcw_pkg::CMD_READ) ? ST_RD0 : ST_PUT;
          end
        end
        ST_PUT: begin
          if (!is_newline || last_col) begin
            if (last_col) begin
              cursor_col <= '0;
              if (prow == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                prow <= '0;
                row_base <= '0;
              end else begin
                prow <= prow + tcw_pkg::ROW_W'(1);
                row_base <= row_base + tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS);
              end
              if (cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                top <= (top == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ?
                       '0 : top + tcw_pkg::ROW_W'(1);
                state <= ST_SCR;
              end else begin
                cursor_row <= cursor_row + tcw_pkg::ROW_W'(1);
                state <= ST_FIN;
              end
            end else begin
              cursor_col <= col_inc;
              state <= ST_FIN;
            end
          end else begin
            cursor_col <= col_inc;
          end
        end
        ST_SCR: begin
          if (last_col) begin
            cursor_col <= '0;
            state <= ST_FIN;
          end else begin
            cursor_col <= col_inc;
          end
        end
        ST_FIN: begin
          done <= 1'b1;
          rsp.cell_entry <= '0;
          rsp.row_now <= 5'(cursor_row);
          rsp.col_now <= 7'(cursor_col);
          state <= ST_IDLE;
        end
        ST_RD0: begin
          rd_prow <= tcw_pkg::ROW_W'(rd_wrap);
          state <= ST_RD1;
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          done <= 1'b1;
          rsp.cell_entry <= rd_out ? '0 : rdata;
          rsp.row_now <= 5'(cursor_row);
          rsp.col_now <= 7'(cursor_col);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
